// File: rtl/spr_pkg.sv
`timescale 1ns / 1ps
package spr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    localparam logic [DATA_W-1:0] START_PERIOD_RST = 32'd100000;
    localparam logic [DATA_W-1:0] MIN_PERIOD_RST   = 32'd1;
    localparam logic [DATA_W-1:0] ACCEL_STEP_RST   = 32'd100;
    localparam logic [DATA_W-1:0] DECEL_STEP_RST   = 32'd100;

    typedef enum logic [1:0] {
        REG_START_PERIOD = 2'd0,
        REG_MIN_PERIOD   = 2'd1,
        REG_ACCEL_STEP   = 2'd2,
        REG_DECEL_STEP   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_START      = 2'd2,
        CMD_STOP       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_STOPPED  = 3'd0,
        MODE_STOPPING = 3'd1,
        MODE_STARTING = 3'd2,
        MODE_ACCEL    = 3'd3,
        MODE_COAST    = 3'd4,
        MODE_DECEL    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [DATA_W-1:0] start_period;
        logic [DATA_W-1:0] min_period;
        logic [DATA_W-1:0] accel_step;
        logic [DATA_W-1:0] decel_step;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] current_period;
        logic [DATA_W-1:0] goal_period;
        mode_t             mode;
        logic              enabled;
    } state_t;

    typedef struct packed {
        logic              period_valid;
        logic [DATA_W-1:0] step_period;
        logic [2:0]        motor_mode;
        logic              running;
    } result_t;

endpackage

// File: rtl/spr_item_if.sv
`timescale 1ns / 1ps
interface spr_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] target_period;

    modport source (output valid, output command, output target_period, input ready);
    modport sink (input valid, input command, input target_period, output ready);
endinterface

// File: rtl/spr_result_if.sv
`timescale 1ns / 1ps
interface spr_result_if;
    logic        valid;
    logic        ready;
    logic        period_valid;
    logic [31:0] step_period;
    logic [2:0]  motor_mode;
    logic        running;

    modport source (output valid, output period_valid, output step_period,
                    output motor_mode, output running, input ready);
    modport sink (input valid, input period_valid, input step_period,
                  input motor_mode, input running, output ready);
endinterface

// File: rtl/spr_cfg_regs.sv
`timescale 1ns / 1ps
module spr_cfg_regs
    import spr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_period <= START_PERIOD_RST;
            cfg_reg.min_period   <= MIN_PERIOD_RST;
            cfg_reg.accel_step   <= ACCEL_STEP_RST;
            cfg_reg.decel_step   <= DECEL_STEP_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START_PERIOD: cfg_reg.start_period <= pwdata;
                REG_MIN_PERIOD:   cfg_reg.min_period   <= pwdata;
                REG_ACCEL_STEP:   cfg_reg.accel_step   <= pwdata;
                REG_DECEL_STEP:   cfg_reg.decel_step   <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_PERIOD: prdata = cfg_reg.start_period;
            REG_MIN_PERIOD:   prdata = cfg_reg.min_period;
            REG_ACCEL_STEP:   prdata = cfg_reg.accel_step;
            REG_DECEL_STEP:   prdata = cfg_reg.decel_step;
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/spr_step_logic.sv
`timescale 1ns / 1ps
module spr_step_logic
    import spr_pkg::*;
(
    input  cfg_t              cfg,
    input  state_t            state,
    input  cmd_t              command,
    input  logic [DATA_W-1:0] target_period,
    output state_t            state_next,
    output result_t           result
);

    logic [DATA_W-1:0] acc_diff;
    logic              acc_to_min;
    logic [DATA_W-1:0] acc_period;
    logic [DATA_W-1:0] acc_goal;
    logic [DATA_W:0]   dec_sum;
    logic [DATA_W-1:0] dec_sat;
    logic [DATA_W-1:0] dec_goal_clamp;
    logic [DATA_W-1:0] dec_period;
    logic [DATA_W-1:0] tp_clamp;
    logic              emit;
    logic [DATA_W-1:0] emit_period;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] goal;

    assign cur  = state.current_period;
    assign goal = state.goal_period;

    // accelerate: subtract and clamp to min, then to goal
    always_comb
    begin
        acc_diff   = cur - cfg.accel_step;
        acc_to_min = (cur < cfg.accel_step) || (acc_diff <= cfg.min_period);
        if (acc_to_min)
            acc_period = cfg.min_period;
        else if (acc_diff <= goal)
            acc_period = goal;
        else
            acc_period = acc_diff;
        acc_goal = acc_to_min ? cfg.min_period : goal;
    end

    // decelerate: saturating add, clamp to goal, then to start
    always_comb
    begin
        dec_sum        = {1'b0, cur} + {1'b0, cfg.decel_step};
        dec_sat        = dec_sum[DATA_W] ? {DATA_W{1'b1}} : dec_sum[DATA_W-1:0];
        dec_goal_clamp = (dec_sat >= goal) ? goal : dec_sat;
        dec_period     = (dec_goal_clamp >= cfg.start_period) ? cfg.start_period
                                                              : dec_goal_clamp;
    end

    assign tp_clamp = (target_period > cfg.start_period) ? cfg.start_period : target_period;

    always_comb
    begin
        state_next  = state;
        emit        = 1'b0;
        emit_period = '0;
        case (command)
            CMD_TICK:
            begin
                if (state.enabled)
                begin
                    case (state.mode)
                        MODE_STOPPING:
                        begin
                            if (cur >= cfg.start_period)
                            begin
                                state_next.enabled = 1'b0;
                                state_next.mode    = MODE_STOPPED;
                            end
                            else
                            begin
                                state_next.current_period = dec_period;
                                emit        = 1'b1;
                                emit_period = dec_period;
                            end
                        end
                        MODE_STARTING:
                        begin
                            emit = 1'b1;
                            if (cur < cfg.start_period)
                            begin
                                state_next.mode           = MODE_ACCEL;
                                state_next.current_period = acc_period;
                                state_next.goal_period    = acc_goal;
                                emit_period               = acc_period;
                            end
                            else if (cur <= goal)
                            begin
                                state_next.mode = MODE_COAST;
                                emit_period     = cur;
                            end
                            else
                            begin
                                state_next.mode = MODE_ACCEL;
                                emit_period     = cur;
                            end
                        end
                        MODE_ACCEL:
                        begin
                            emit = 1'b1;
                            if (cur > goal)
                            begin
                                state_next.current_period = acc_period;
                                state_next.goal_period    = acc_goal;
                                emit_period               = acc_period;
                            end
                            else
                            begin
                                state_next.mode = MODE_COAST;
                                emit_period     = cur;
                            end
                        end
                        MODE_COAST:
                        begin
                            if (cur == goal)
                            begin
                                emit        = 1'b1;
                                emit_period = cur;
                            end
                        end
                        MODE_DECEL:
                        begin
                            emit = 1'b1;
                            if (cur < goal)
                            begin
                                state_next.current_period = dec_period;
                                emit_period               = dec_period;
                            end
                            else
                            begin
                                state_next.mode = MODE_COAST;
                                emit_period     = cur;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_SET_TARGET:
            begin
                if (target_period == '0)
                    state_next.goal_period = cfg.start_period;
                else if (tp_clamp < cur)
                begin
                    state_next.goal_period = (tp_clamp < cfg.min_period) ? cfg.min_period
                                                                         : tp_clamp;
                    if (state.mode != MODE_STARTING && state.mode != MODE_ACCEL)
                        state_next.mode = MODE_ACCEL;
                end
                else if (tp_clamp > cur)
                begin
                    state_next.goal_period = tp_clamp;
                    state_next.mode        = MODE_DECEL;
                end
                else
                    state_next.goal_period = tp_clamp;
            end
            CMD_START:
            begin
                if (!state.enabled)
                begin
                    state_next.enabled        = 1'b1;
                    state_next.current_period = cfg.start_period;
                    state_next.mode           = MODE_STARTING;
                end
            end
            CMD_STOP:
            begin
                if (state.enabled)
                begin
                    state_next.goal_period = cfg.start_period;
                    state_next.mode        = MODE_STOPPING;
                end
            end
            default: ;
        endcase
    end

    assign result.period_valid = emit;
    assign result.step_period  = emit_period;
    assign result.motor_mode   = state_next.mode;
    assign result.running      = state_next.enabled;

endmodule

// File: rtl/stepper_period_ramp_controller_top.sv
`timescale 1ns / 1ps
// Step-period ramp controller. Each command word is captured in an input register and applied to
// the ramp state once the output register is free or its word is being taken; its result word is
// then held in an output register. One command word is accepted every cycle while the result
// side keeps taking words; the period, goal, mode and enable registers are all updated when a
// command advances, which lets that rate hold. Registers sit at byte addresses 0x0 start period,
// 0x4 min period, 0x8 accel step, 0xC decel step; write them only while no command is in flight.
module stepper_period_ramp_controller_top
    import spr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    spr_item_if.sink          item,
    spr_result_if.source      result
);

    cfg_t              cfg;
    state_t            state_reg;
    state_t            state_next;
    result_t           res_next;
    result_t           res_reg;
    logic              res_valid_reg;
    logic              s1_valid_reg;
    logic [1:0]        s1_cmd_reg;
    logic [DATA_W-1:0] s1_tp_reg;
    logic              advance;
    logic              take_in;

    spr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spr_step_logic u_step (
        .cfg           (cfg),
        .state         (state_reg),
        .command       (cmd_t'(s1_cmd_reg)),
        .target_period (s1_tp_reg),
        .state_next    (state_next),
        .result        (res_next)
    );

    assign advance    = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign take_in    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg.current_period <= START_PERIOD_RST;
            state_reg.goal_period    <= START_PERIOD_RST;
            state_reg.mode           <= MODE_STOPPED;
            state_reg.enabled        <= 1'b0;
        end
        else
        begin
            if (take_in)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_cmd_reg <= item.command;
            s1_tp_reg  <= item.target_period;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.period_valid = res_reg.period_valid;
    assign result.step_period  = res_reg.step_period;
    assign result.motor_mode   = res_reg.motor_mode;
    assign result.running      = res_reg.running;

endmodule
